// ===== hdl/pftt_pkg.sv =====
// ----------------------------------------------------------------------------
// Page frame type table package
// Widths, item kind codes and shared types for the page frame type table.
// ----------------------------------------------------------------------------
package pftt_pkg;

    localparam int MAX_FRAMES = 4096;
    localparam int NUM_TYPES  = 10;

    localparam int ADDR_W   = $clog2(MAX_FRAMES);
    localparam int TYPE_W   = 4;
    localparam int COUNT_W  = 32;
    localparam int FCOUNT_W = 13;

    typedef logic [ADDR_W-1:0]   addr_t;
    typedef logic [TYPE_W-1:0]   type_t;
    typedef logic [COUNT_W-1:0]  count_t;
    typedef logic [FCOUNT_W-1:0] fcount_t;
    typedef logic [1:0]          kind_t;

    localparam kind_t KIND_ADD   = 2'd0;
    localparam kind_t KIND_SET   = 2'd1;
    localparam kind_t KIND_SUB   = 2'd2;
    localparam kind_t KIND_QUERY = 2'd3;

    localparam count_t  COUNT_MAX     = '1;
    localparam fcount_t FCOUNT_RESET  = fcount_t'(4096);
    localparam fcount_t FRAMES_LIMIT  = fcount_t'(MAX_FRAMES);

    typedef struct packed {
        logic  dec_en;
        type_t dec_type;
        logic  inc_en;
        type_t inc_type;
    } cnt_upd_t;

endpackage

// ===== hdl/pftt_req_if.sv =====
// ----------------------------------------------------------------------------
// Page frame type table request channel
// Valid/ready channel that carries one operation per transfer.
// ----------------------------------------------------------------------------
interface pftt_req_if;

    logic            valid;
    logic            ready;
    pftt_pkg::kind_t kind;
    pftt_pkg::addr_t frame;
    pftt_pkg::type_t new_type;
    pftt_pkg::type_t match_type;

    modport source (output valid, output kind, output frame, output new_type,
                    output match_type, input ready);
    modport sink   (input valid, input kind, input frame, input new_type,
                    input match_type, output ready);

endinterface

// ===== hdl/pftt_rsp_if.sv =====
// ----------------------------------------------------------------------------
// Page frame type table response channel
// Valid/ready channel that carries one result per transfer.
// ----------------------------------------------------------------------------
interface pftt_rsp_if;

    logic              valid;
    logic              ready;
    pftt_pkg::type_t   old_type;
    logic              applied;
    pftt_pkg::count_t  type_count;
    pftt_pkg::fcount_t entries_changed;
    logic              error;

    modport source (output valid, output old_type, output applied, output type_count,
                    output entries_changed, output error, input ready);
    modport sink   (input valid, input old_type, input applied, input type_count,
                    input entries_changed, input error, output ready);

endinterface

// ===== hdl/page_frame_type_table.sv =====
// ----------------------------------------------------------------------------
// Page frame type table
// Keeps a type code per page frame and a usage counter per type. Supports
// conditional add, set, substitute over all tracked frames, and query.
//
//   Channel  Dir  Handshake       Payload
//   req      in   valid / ready   kind, frame, new_type, match_type
//   rsp      out  valid / ready   old_type, applied, type_count,
//                                 entries_changed, error
//   cfg      in   cfg_we          cfg_wdata (frame_count)
//
// Add, set and query go from the transfer cycle, which issues the store read,
// through the update state S_LOOK to the report state S_REPORT, which loads
// the result registers. Substitute steps through min(frame_count, 4096) store
// entries in S_SCAN, one store entry per cycle through the read port, then
// reports. A rejected item goes from the transfer straight to S_REPORT.
// After reset all 4096 store entries are cleared one entry per cycle, while
// req.ready stays low. A waiting result does not block the next transfer in;
// only the report of the following item waits for rsp to drain.
// ----------------------------------------------------------------------------
module page_frame_type_table (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  pftt_pkg::fcount_t cfg_wdata,
    pftt_req_if.sink          req,
    pftt_rsp_if.source        rsp
);

    localparam logic [2:0] S_CLEAR  = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_LOOK   = 3'd2;
    localparam logic [2:0] S_SCAN   = 3'd3;
    localparam logic [2:0] S_REPORT = 3'd4;

    logic [2:0]        state_reg,       state_next;
    pftt_pkg::fcount_t frame_count_reg;
    pftt_pkg::kind_t   kind_reg,        kind_next;
    pftt_pkg::addr_t   frame_reg,       frame_next;
    pftt_pkg::type_t   ntype_reg,       ntype_next;
    pftt_pkg::type_t   mtype_reg,       mtype_next;
    pftt_pkg::fcount_t limit_reg,       limit_next;
    pftt_pkg::addr_t   idx_reg,         idx_next;
    pftt_pkg::type_t   old_reg,         old_next;
    logic              applied_reg,     applied_next;
    pftt_pkg::fcount_t changed_reg,     changed_next;
    logic              err_reg,         err_next;

    logic              rsp_valid_reg,   rsp_valid_next;
    pftt_pkg::type_t   rsp_old_reg,     rsp_old_next;
    logic              rsp_applied_reg, rsp_applied_next;
    pftt_pkg::count_t  rsp_count_reg,   rsp_count_next;
    pftt_pkg::fcount_t rsp_changed_reg, rsp_changed_next;
    logic              rsp_error_reg,   rsp_error_next;

    logic               wr_en;
    pftt_pkg::addr_t    wr_addr;
    pftt_pkg::type_t    wr_data;
    pftt_pkg::addr_t    rd_addr;
    pftt_pkg::type_t    rd_data;
    pftt_pkg::cnt_upd_t upd;
    pftt_pkg::count_t   cnt_rd;

    pftt_pkg::fcount_t limit_w;
    pftt_pkg::fcount_t idx_plus;
    logic              req_err;
    logic              do_write;
    logic              scan_hit;
    logic              rsp_free;

    pftt_store u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    pftt_counters u_counters (
        .clk      (clk),
        .rst_n    (rst_n),
        .upd      (upd),
        .rd_type  (ntype_reg),
        .rd_count (cnt_rd)
    );

    assign limit_w  = (frame_count_reg > pftt_pkg::FRAMES_LIMIT) ?
                      pftt_pkg::FRAMES_LIMIT : frame_count_reg;
    assign idx_plus = pftt_pkg::fcount_t'(idx_reg) + pftt_pkg::fcount_t'(1);
    assign rsp_free = !rsp_valid_reg || rsp.ready;
    assign req.ready = (state_reg == S_IDLE);

    always_comb
    begin
        req_err = 1'b0;
        if (int'(req.new_type) >= pftt_pkg::NUM_TYPES)
        begin
            req_err = 1'b1;
        end
        else if (req.kind == pftt_pkg::KIND_SUB)
        begin
            req_err = (int'(req.match_type) >= pftt_pkg::NUM_TYPES);
        end
        else
        begin
            req_err = (pftt_pkg::fcount_t'(req.frame) >= limit_w);
        end
    end

    assign do_write = (kind_reg == pftt_pkg::KIND_SET) ||
                      ((kind_reg == pftt_pkg::KIND_ADD) && (rd_data <= ntype_reg));
    assign scan_hit = (rd_data == mtype_reg);

    always_comb
    begin
        state_next       = state_reg;
        kind_next        = kind_reg;
        frame_next       = frame_reg;
        ntype_next       = ntype_reg;
        mtype_next       = mtype_reg;
        limit_next       = limit_reg;
        idx_next         = idx_reg;
        old_next         = old_reg;
        applied_next     = applied_reg;
        changed_next     = changed_reg;
        err_next         = err_reg;
        rsp_valid_next   = rsp_valid_reg && !rsp.ready;
        rsp_old_next     = rsp_old_reg;
        rsp_applied_next = rsp_applied_reg;
        rsp_count_next   = rsp_count_reg;
        rsp_changed_next = rsp_changed_reg;
        rsp_error_next   = rsp_error_reg;
        wr_en            = 1'b0;
        wr_addr          = idx_reg;
        wr_data          = ntype_reg;
        rd_addr          = (req.kind == pftt_pkg::KIND_SUB) ? '0 : req.frame;
        upd              = '0;

        case (state_reg)
            S_CLEAR:
            begin
                wr_en   = 1'b1;
                wr_data = '0;
                if (idx_reg == pftt_pkg::addr_t'(pftt_pkg::MAX_FRAMES - 1))
                begin
                    idx_next   = '0;
                    state_next = S_IDLE;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            S_IDLE:
            begin
                if (req.valid)
                begin
                    kind_next    = req.kind;
                    frame_next   = req.frame;
                    ntype_next   = req.new_type;
                    mtype_next   = req.match_type;
                    limit_next   = limit_w;
                    idx_next     = '0;
                    old_next     = '0;
                    applied_next = 1'b0;
                    changed_next = '0;
                    err_next     = req_err;
                    if (req_err)
                    begin
                        state_next = S_REPORT;
                    end
                    else if (req.kind == pftt_pkg::KIND_SUB)
                    begin
                        state_next = (limit_w == '0) ? S_REPORT : S_SCAN;
                    end
                    else
                    begin
                        state_next = S_LOOK;
                    end
                end
            end
            S_LOOK:
            begin
                old_next = rd_data;
                wr_addr  = frame_reg;
                if (do_write)
                begin
                    wr_en        = 1'b1;
                    upd.dec_en   = 1'b1;
                    upd.dec_type = rd_data;
                    upd.inc_en   = 1'b1;
                    upd.inc_type = ntype_reg;
                    applied_next = 1'b1;
                    changed_next = pftt_pkg::fcount_t'(1);
                end
                state_next = S_REPORT;
            end
            S_SCAN:
            begin
                rd_addr = idx_plus[pftt_pkg::ADDR_W-1:0];
                if (scan_hit)
                begin
                    wr_en        = 1'b1;
                    upd.dec_en   = 1'b1;
                    upd.dec_type = mtype_reg;
                    upd.inc_en   = 1'b1;
                    upd.inc_type = ntype_reg;
                    applied_next = 1'b1;
                    changed_next = changed_reg + 1'b1;
                end
                if (idx_plus == limit_reg)
                begin
                    state_next = S_REPORT;
                end
                else
                begin
                    idx_next = idx_plus[pftt_pkg::ADDR_W-1:0];
                end
            end
            S_REPORT:
            begin
                if (rsp_free)
                begin
                    rsp_valid_next   = 1'b1;
                    rsp_old_next     = err_reg ? '0 : old_reg;
                    rsp_applied_next = applied_reg;
                    rsp_count_next   = err_reg ? '0 : cnt_rd;
                    rsp_changed_next = changed_reg;
                    rsp_error_next   = err_reg;
                    state_next       = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_CLEAR;
            frame_count_reg <= pftt_pkg::FCOUNT_RESET;
            idx_reg         <= '0;
            rsp_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            rsp_valid_reg <= rsp_valid_next;
            if (cfg_we)
            begin
                frame_count_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg        <= kind_next;
        frame_reg       <= frame_next;
        ntype_reg       <= ntype_next;
        mtype_reg       <= mtype_next;
        limit_reg       <= limit_next;
        old_reg         <= old_next;
        applied_reg     <= applied_next;
        changed_reg     <= changed_next;
        err_reg         <= err_next;
        rsp_old_reg     <= rsp_old_next;
        rsp_applied_reg <= rsp_applied_next;
        rsp_count_reg   <= rsp_count_next;
        rsp_changed_reg <= rsp_changed_next;
        rsp_error_reg   <= rsp_error_next;
    end

    assign rsp.valid           = rsp_valid_reg;
    assign rsp.old_type        = rsp_old_reg;
    assign rsp.applied         = rsp_applied_reg;
    assign rsp.type_count      = rsp_count_reg;
    assign rsp.entries_changed = rsp_changed_reg;
    assign rsp.error           = rsp_error_reg;

    a_no_write_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE || state_reg == S_REPORT) |-> !wr_en)
        else $error("Store written outside an update or clear cycle.");

    a_result_from_report: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) |-> $past(state_reg == S_REPORT))
        else $error("Result appeared without a report cycle.");

    a_error_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.error) |-> (rsp.old_type == '0 && !rsp.applied &&
                                      rsp.type_count == '0 && rsp.entries_changed == '0))
        else $error("Rejected item reported nonzero fields.");

    a_scan_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> (changed_reg <= pftt_pkg::fcount_t'(idx_reg)))
        else $error("Substitute count ran ahead of the scan index.");

endmodule

// ===== hdl/pftt_store.sv =====
// ----------------------------------------------------------------------------
// Frame type store
// One write port and one registered read port over the per-frame type codes.
// ----------------------------------------------------------------------------
module pftt_store (
    input  logic            clk,
    input  logic            wr_en,
    input  pftt_pkg::addr_t wr_addr,
    input  pftt_pkg::type_t wr_data,
    input  pftt_pkg::addr_t rd_addr,
    output pftt_pkg::type_t rd_data
);

    pftt_pkg::type_t mem [pftt_pkg::MAX_FRAMES];
    pftt_pkg::type_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hdl/pftt_counters.sv =====
// ----------------------------------------------------------------------------
// Type usage counters
// One saturating counter per type. A decrement and an increment may hit the
// same counter in one cycle; the decrement is applied first.
// ----------------------------------------------------------------------------
module pftt_counters (
    input  logic               clk,
    input  logic               rst_n,
    input  pftt_pkg::cnt_upd_t upd,
    input  pftt_pkg::type_t    rd_type,
    output pftt_pkg::count_t   rd_count
);

    pftt_pkg::count_t count_reg  [pftt_pkg::NUM_TYPES];
    pftt_pkg::count_t count_next [pftt_pkg::NUM_TYPES];

    for (genvar g = 0; g < pftt_pkg::NUM_TYPES; g++)
    begin : g_lane
        logic dec_hit;
        logic inc_hit;

        // Type 0 marks an invalid frame and is never decremented.
        assign dec_hit = upd.dec_en && (g != 0) &&
                         (upd.dec_type == pftt_pkg::type_t'(g));
        assign inc_hit = upd.inc_en && (upd.inc_type == pftt_pkg::type_t'(g));

        always_comb
        begin
            count_next[g] = count_reg[g];
            if (dec_hit && inc_hit)
            begin
                if (count_reg[g] == '0)
                begin
                    count_next[g] = pftt_pkg::count_t'(1);
                end
            end
            else if (dec_hit)
            begin
                if (count_reg[g] != '0)
                begin
                    count_next[g] = count_reg[g] - 1'b1;
                end
            end
            else if (inc_hit)
            begin
                if (count_reg[g] != pftt_pkg::COUNT_MAX)
                begin
                    count_next[g] = count_reg[g] + 1'b1;
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                count_reg[g] <= '0;
            end
            else
            begin
                count_reg[g] <= count_next[g];
            end
        end
    end

    assign rd_count = (int'(rd_type) < pftt_pkg::NUM_TYPES) ? count_reg[rd_type] : '0;

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Page frame type table testbench
// Sends add, set, substitute and query operations over the request channel
// and compares every result field with a behavioral model of the type store
// and the usage counters. The run uses several frame count settings and
// random idle bursts on both channels.
// ----------------------------------------------------------------------------
module tb;

    localparam int CYCLE_LIMIT = 1000000;

    typedef struct packed {
        pftt_pkg::type_t   old_type;
        logic              applied;
        pftt_pkg::count_t  type_count;
        pftt_pkg::fcount_t entries_changed;
        logic              error;
    } table_result_t;

    logic              clk;
    logic              rst_n;
    logic              cfg_we;
    pftt_pkg::fcount_t cfg_wdata;

    pftt_req_if req_ch ();
    pftt_rsp_if rsp_ch ();

    page_frame_type_table dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .req       (req_ch),
        .rsp       (rsp_ch)
    );

    pftt_pkg::type_t   table_types [pftt_pkg::MAX_FRAMES];
    pftt_pkg::count_t  usage_counts [pftt_pkg::NUM_TYPES];
    pftt_pkg::fcount_t frame_count_setting;
    table_result_t     pending_results [$];
    int                mismatch_count;
    int                cycle_count;
    int                stall_left;
    bit                gaps_on;

    initial clk = 1'b0;

    always
    begin
        #10 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    function automatic int tracked_frames();
        if (frame_count_setting > pftt_pkg::FRAMES_LIMIT)
            return pftt_pkg::MAX_FRAMES;
        return int'(frame_count_setting);
    endfunction

    function automatic void count_up(pftt_pkg::type_t t);
        if (t < pftt_pkg::NUM_TYPES && usage_counts[t] != pftt_pkg::COUNT_MAX)
            usage_counts[t] = usage_counts[t] + 1'b1;
    endfunction

    function automatic void count_down(pftt_pkg::type_t t);
        if (t != 0 && t < pftt_pkg::NUM_TYPES && usage_counts[t] != 0)
            usage_counts[t] = usage_counts[t] - 1'b1;
    endfunction

    function automatic table_result_t apply_table_op(pftt_pkg::kind_t op_kind,
                                                     pftt_pkg::addr_t frame,
                                                     pftt_pkg::type_t new_type,
                                                     pftt_pkg::type_t match_type);
        table_result_t r;
        int            span;
        r    = '0;
        span = tracked_frames();
        if (new_type >= pftt_pkg::NUM_TYPES)
        begin
            r.error = 1'b1;
        end
        else if (op_kind == pftt_pkg::KIND_SUB)
        begin
            if (match_type >= pftt_pkg::NUM_TYPES)
            begin
                r.error = 1'b1;
            end
            else
            begin
                for (int i = 0; i < span; i++)
                begin
                    if (table_types[i] == match_type)
                    begin
                        table_types[i] = new_type;
                        count_down(match_type);
                        count_up(new_type);
                        r.entries_changed = r.entries_changed + 1'b1;
                    end
                end
                r.applied = (r.entries_changed != 0);
            end
        end
        else if (frame >= span)
        begin
            r.error = 1'b1;
        end
        else
        begin
            r.old_type = table_types[frame];
            if (op_kind == pftt_pkg::KIND_SET ||
                (op_kind == pftt_pkg::KIND_ADD && r.old_type <= new_type))
            begin
                table_types[frame] = new_type;
                count_down(r.old_type);
                count_up(new_type);
                r.applied         = 1'b1;
                r.entries_changed = pftt_pkg::fcount_t'(1);
            end
        end
        if (!r.error)
            r.type_count = usage_counts[new_type];
        return r;
    endfunction

    task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
        $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, field, got, want);
        mismatch_count++;
    endtask

    always @(posedge clk)
    begin
        if (stall_left != 0)
        begin
            rsp_ch.ready <= 1'b0;
            stall_left   <= stall_left - 1;
        end
        else if (gaps_on && $urandom_range(0, 7) == 0)
        begin
            rsp_ch.ready <= 1'b0;
            stall_left   <= int'($urandom_range(0, 10));
        end
        else
        begin
            rsp_ch.ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        table_result_t want;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (pending_results.size() == 0)
            begin
                report_mismatch("result with nothing pending", rsp_ch.type_count, 32'(0));
            end
            else
            begin
                want = pending_results.pop_front();
                if (rsp_ch.old_type !== want.old_type)
                    report_mismatch("old_type", 32'(rsp_ch.old_type), 32'(want.old_type));
                if (rsp_ch.applied !== want.applied)
                    report_mismatch("applied", 32'(rsp_ch.applied), 32'(want.applied));
                if (rsp_ch.type_count !== want.type_count)
                    report_mismatch("type_count", rsp_ch.type_count, want.type_count);
                if (rsp_ch.entries_changed !== want.entries_changed)
                    report_mismatch("entries_changed", 32'(rsp_ch.entries_changed),
                                    32'(want.entries_changed));
                if (rsp_ch.error !== want.error)
                    report_mismatch("error", 32'(rsp_ch.error), 32'(want.error));
            end
        end
    end

    task automatic send_op(pftt_pkg::kind_t op_kind, int frame, int new_type, int match_type);
        int              gap;
        pftt_pkg::addr_t op_frame;
        pftt_pkg::type_t op_new;
        pftt_pkg::type_t op_match;
        op_frame = pftt_pkg::addr_t'(frame);
        op_new   = pftt_pkg::type_t'(new_type);
        op_match = pftt_pkg::type_t'(match_type);
        if (gaps_on && $urandom_range(0, 4) == 0)
        begin
            gap = int'($urandom_range(1, 11));
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid      <= 1'b1;
        req_ch.kind       <= op_kind;
        req_ch.frame      <= op_frame;
        req_ch.new_type   <= op_new;
        req_ch.match_type <= op_match;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        pending_results.push_back(apply_table_op(op_kind, op_frame, op_new, op_match));
    endtask

    task automatic wait_until_drained();
        req_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_results.size() != 0);
    endtask

    task automatic write_frame_count(int value);
        pftt_pkg::fcount_t setting;
        setting = pftt_pkg::fcount_t'(value);
        wait_until_drained();
        cfg_we    <= 1'b1;
        cfg_wdata <= setting;
        @(posedge clk);
        frame_count_setting = setting;
        cfg_we <= 1'b0;
    endtask

    task automatic send_random_ops(int count, int sub_pct);
        int              span;
        int              pick;
        pftt_pkg::kind_t op_kind;
        int              frame;
        int              new_type;
        int              match_type;
        for (int n = 0; n < count; n++)
        begin
            span = tracked_frames();
            if ($urandom_range(0, 99) < sub_pct)
            begin
                op_kind = pftt_pkg::KIND_SUB;
            end
            else
            begin
                case ($urandom_range(0, 2))
                    0:       op_kind = pftt_pkg::KIND_ADD;
                    1:       op_kind = pftt_pkg::KIND_SET;
                    default: op_kind = pftt_pkg::KIND_QUERY;
                endcase
            end
            pick = int'($urandom_range(0, 9));
            if (span == 0 || pick == 0)
                frame = int'($urandom_range(0, pftt_pkg::MAX_FRAMES - 1));
            else if (pick == 1 && span < pftt_pkg::MAX_FRAMES)
                frame = span;
            else
                frame = int'($urandom_range(0, span - 1));
            if ($urandom_range(0, 9) == 0)
                new_type = int'($urandom_range(pftt_pkg::NUM_TYPES, 15));
            else
                new_type = int'($urandom_range(0, pftt_pkg::NUM_TYPES - 1));
            if ($urandom_range(0, 9) == 0)
                match_type = int'($urandom_range(pftt_pkg::NUM_TYPES, 15));
            else
                match_type = int'($urandom_range(0, pftt_pkg::NUM_TYPES - 1));
            send_op(op_kind, frame, new_type, match_type);
        end
    endtask

    task automatic test_basic_ops();
        send_op(pftt_pkg::KIND_QUERY, 0, 0, 0);
        send_op(pftt_pkg::KIND_ADD, 0, 0, 0);
        send_op(pftt_pkg::KIND_ADD, pftt_pkg::MAX_FRAMES - 1, pftt_pkg::NUM_TYPES - 1, 0);
        send_op(pftt_pkg::KIND_ADD, pftt_pkg::MAX_FRAMES - 1, 3, 0);
        send_op(pftt_pkg::KIND_SET, pftt_pkg::MAX_FRAMES - 1, 3, 0);
        send_op(pftt_pkg::KIND_SET, pftt_pkg::MAX_FRAMES - 1, 3, 0);
        send_op(pftt_pkg::KIND_QUERY, pftt_pkg::MAX_FRAMES - 1, pftt_pkg::NUM_TYPES - 1, 15);
        send_op(pftt_pkg::KIND_ADD, 1, 15, 0);
        send_op(pftt_pkg::KIND_SET, 2, pftt_pkg::NUM_TYPES, 0);
        send_op(pftt_pkg::KIND_QUERY, 3, 12, 0);
        send_op(pftt_pkg::KIND_SUB, 0, 15, 2);
        send_op(pftt_pkg::KIND_SUB, 0, 2, pftt_pkg::NUM_TYPES);
        send_op(pftt_pkg::KIND_SUB, 0, 3, 3);
        send_op(pftt_pkg::KIND_SUB, 0, 1, 7);
        send_op(pftt_pkg::KIND_SUB, 0, 5, 0);
    endtask

    task automatic test_frame_bounds();
        write_frame_count(100);
        send_op(pftt_pkg::KIND_ADD, 99, 4, 0);
        send_op(pftt_pkg::KIND_ADD, 100, 4, 0);
        send_op(pftt_pkg::KIND_SET, pftt_pkg::MAX_FRAMES - 1, 1, 0);
        send_op(pftt_pkg::KIND_QUERY, 100, 4, 0);
        send_op(pftt_pkg::KIND_QUERY, 99, 4, 0);
        write_frame_count(0);
        send_op(pftt_pkg::KIND_ADD, 0, 1, 0);
        send_op(pftt_pkg::KIND_SUB, 0, 6, 5);
        write_frame_count(-1);
        send_op(pftt_pkg::KIND_QUERY, pftt_pkg::MAX_FRAMES - 1, 3, 0);
        send_op(pftt_pkg::KIND_SET, pftt_pkg::MAX_FRAMES - 1, 8, 0);
        send_op(pftt_pkg::KIND_SUB, 0, 2, 8);
        write_frame_count(1);
        send_op(pftt_pkg::KIND_ADD, 0, 7, 0);
        send_op(pftt_pkg::KIND_ADD, 1, 7, 0);
        send_op(pftt_pkg::KIND_SUB, 0, 0, 7);
    endtask

    task automatic test_large_table();
        write_frame_count(pftt_pkg::MAX_FRAMES);
        send_random_ops(80, 3);
        write_frame_count(-1);
        send_random_ops(40, 5);
    endtask

    task automatic test_random_mix();
        for (int p = 0; p < 13; p++)
        begin
            if (p % 4 == 0)
                write_frame_count(int'($urandom_range(49, 300)));
            else
                write_frame_count(int'($urandom_range(1, 48)));
            send_random_ops(120, 25);
        end
    endtask

    task automatic test_no_gaps();
        write_frame_count(int'($urandom_range(1, 64)));
        gaps_on = 1'b0;
        send_random_ops(200, 25);
    endtask

    initial
    begin
        rst_n             = 1'b0;
        cfg_we            = 1'b0;
        cfg_wdata         = pftt_pkg::FCOUNT_RESET;
        req_ch.valid      = 1'b0;
        req_ch.kind       = pftt_pkg::KIND_QUERY;
        req_ch.frame      = '0;
        req_ch.new_type   = '0;
        req_ch.match_type = '0;
        rsp_ch.ready      = 1'b0;
        mismatch_count    = 0;
        cycle_count       = 0;
        stall_left        = 0;
        gaps_on           = 1'b1;
        for (int i = 0; i < pftt_pkg::MAX_FRAMES; i++)
            table_types[i] = '0;
        for (int i = 0; i < pftt_pkg::NUM_TYPES; i++)
            usage_counts[i] = '0;
        frame_count_setting = pftt_pkg::FCOUNT_RESET;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        test_basic_ops();
        test_frame_bounds();
        test_large_table();
        test_random_mix();
        test_no_gaps();

        wait_until_drained();
        repeat (20) @(posedge clk);
        if (mismatch_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
